// ===== design/psc_pkg.sv =====
package psc_pkg;

   localparam int CHANNELS_DEFAULT  = 4;
   localparam int MID_DEPTH_DEFAULT = 4;
   localparam int OUT_DEPTH_DEFAULT = 16;

   localparam int COEF_W = 16;
   localparam int RAW_W  = 24;
   localparam int CSR_W  = 64;
   localparam int MASK_W = 4;

   typedef enum logic [2:0] {
      CSR_SENS_BASE  = 3'd0,
      CSR_OFF_BASE   = 3'd1,
      CSR_SENS_TC    = 3'd2,
      CSR_OFF_TC     = 3'd3,
      CSR_TREF       = 3'd4,
      CSR_TEMPSENS   = 3'd5,
      CSR_VALID_MASK = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [1:0]       channel;
      logic [RAW_W-1:0] raw_temperature;
      logic [RAW_W-1:0] raw_pressure;
   } req_type;

   typedef struct packed {
      logic signed [RAW_W-1:0] pressure_centi_mbar;
      logic                    valid_res;
   } rsp_type;

   // classified request waiting between front and back
   typedef struct packed {
      logic             valid;
      logic [1:0]       channel;
      logic [RAW_W-1:0] d2;
      logic [RAW_W-1:0] d1;
   } mid_type;

   typedef struct packed {
      logic [CSR_W-1:0] sens_base;
      logic [CSR_W-1:0] off_base;
      logic [CSR_W-1:0] sens_tc;
      logic [CSR_W-1:0] off_tc;
      logic [CSR_W-1:0] tref;
      logic [CSR_W-1:0] tempsens;
   } coef_type;

   function automatic logic [COEF_W-1:0] coef_sel(input logic [CSR_W-1:0] bank,
                                                  input logic [1:0] ch);
      coef_sel = bank[{ch, 4'd0} +: COEF_W];
   endfunction

endpackage

// ===== design/psc_fifo.sv =====
module psc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             full,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ===== design/psc_front.sv =====
module psc_front #(
   parameter int CHANNELS = psc_pkg::CHANNELS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   input  logic [2:0]              csr_index,
   input  logic [psc_pkg::CSR_W-1:0] csr_wdata,
   input  logic                    req_push,
   input  psc_pkg::req_type        req_data,
   input  logic                    mid_full,
   output logic                    mid_push,
   output psc_pkg::mid_type        mid_data,
   output psc_pkg::coef_type       coef
);

   import psc_pkg::*;

   coef_type          coef_ff, coef_in;
   logic [MASK_W-1:0] mask_ff, mask_in;
   logic              chan_ok;

   always_comb begin
      coef_in = coef_ff;
      mask_in = mask_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SENS_BASE:  coef_in.sens_base = csr_wdata;
            CSR_OFF_BASE:   coef_in.off_base  = csr_wdata;
            CSR_SENS_TC:    coef_in.sens_tc   = csr_wdata;
            CSR_OFF_TC:     coef_in.off_tc    = csr_wdata;
            CSR_TREF:       coef_in.tref      = csr_wdata;
            CSR_TEMPSENS:   coef_in.tempsens  = csr_wdata;
            CSR_VALID_MASK: mask_in           = csr_wdata[MASK_W-1:0];
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
         mask_ff <= '0;
      end else begin
         coef_ff <= coef_in;
         mask_ff <= mask_in;
      end
   end

   // channel counts only if it exists and its prom passed the check
   assign chan_ok = ({1'b0, req_data.channel} < 3'(CHANNELS)) & mask_ff[req_data.channel];

   assign mid_push         = req_push & ~mid_full;
   assign mid_data.valid   = chan_ok;
   assign mid_data.channel = req_data.channel;
   assign mid_data.d2      = req_data.raw_temperature;
   assign mid_data.d1      = req_data.raw_pressure;
   assign coef             = coef_ff;

endmodule

// ===== design/psc_back.sv =====
module psc_back #(
   parameter int OUT_DEPTH = psc_pkg::OUT_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  psc_pkg::coef_type coef,
   input  logic              mid_empty,
   input  psc_pkg::mid_type  mid_data,
   output logic              mid_pop,
   input  logic              rsp_pop,
   output logic              rsp_empty,
   output psc_pkg::rsp_type  rsp_data
);

   import psc_pkg::*;

   localparam int CW     = $clog2(OUT_DEPTH + 1);
   localparam int STAGES = 7;

   // credit: requests in the pipe plus results in the output queue
   logic [CW-1:0]     pend_ff, pend_in;
   logic [STAGES:1]   vld_ff, vld_in;
   logic              issue, retire;

   // stage 1
   logic              s1_val_ff, s1_val_in;
   logic [1:0]        s1_ch_ff, s1_ch_in;
   logic [RAW_W-1:0]  s1_d1_ff, s1_d1_in;
   logic signed [24:0] s1_dt_ff, s1_dt_in;
   // stage 2
   logic              s2_val_ff, s2_val_in;
   logic [1:0]        s2_ch_ff, s2_ch_in;
   logic [RAW_W-1:0]  s2_d1_ff, s2_d1_in;
   logic signed [41:0] s2_mt_ff, s2_mt_in;
   logic signed [41:0] s2_mo_ff, s2_mo_in;
   logic signed [41:0] s2_ms_ff, s2_ms_in;
   // stage 3
   logic              s3_val_ff, s3_val_in;
   logic [RAW_W-1:0]  s3_d1_ff, s3_d1_in;
   logic signed [17:0] s3_dev_ff, s3_dev_in;
   logic signed [37:0] s3_off_ff, s3_off_in;
   logic signed [37:0] s3_sens_ff, s3_sens_in;
   // stage 4
   logic              s4_val_ff, s4_val_in;
   logic [RAW_W-1:0]  s4_d1_ff, s4_d1_in;
   logic [34:0]       s4_sq_ff, s4_sq_in;
   logic              s4_neg_ff, s4_neg_in;
   logic signed [37:0] s4_off_ff, s4_off_in;
   logic signed [37:0] s4_sens_ff, s4_sens_in;
   // stage 5
   logic              s5_val_ff, s5_val_in;
   logic [RAW_W-1:0]  s5_d1_ff, s5_d1_in;
   logic signed [37:0] s5_off_ff, s5_off_in;
   logic signed [37:0] s5_sens_ff, s5_sens_in;
   // stage 6
   logic              s6_val_ff, s6_val_in;
   logic [42:0]       s6_plo_ff, s6_plo_in;
   logic signed [43:0] s6_phi_ff, s6_phi_in;
   logic signed [37:0] s6_off_ff, s6_off_in;
   // stage 7
   logic              s7_val_ff, s7_val_in;
   logic signed [63:0] s7_num_ff, s7_num_in;

   logic signed [41:0] mt_adj, mo_adj, ms_adj;
   logic signed [35:0] sq_full;
   logic [39:0]       sq31;
   logic [40:0]       sq63;
   logic [36:0]       off_corr;
   logic [35:0]       sens_corr;
   logic signed [23:0] p_sat;
   rsp_type           out_wdata;
   logic              out_full;
   logic [$bits(rsp_type)-1:0] out_rdata;

   assign issue   = ~mid_empty & (pend_ff < CW'(OUT_DEPTH));
   assign retire  = rsp_pop & ~rsp_empty;
   assign mid_pop = issue;
   assign pend_in = pend_ff + CW'(issue) - CW'(retire);
   assign vld_in  = {vld_ff[STAGES-1:1], issue};

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         vld_ff  <= '0;
      end else begin
         pend_ff <= pend_in;
         vld_ff  <= vld_in;
      end
   end

   always_comb begin
      // dT = D2 - C5 * 256
      s1_val_in = mid_data.valid;
      s1_ch_in  = mid_data.channel;
      s1_d1_in  = mid_data.d1;
      s1_dt_in  = $signed({1'b0, mid_data.d2})
                - $signed({1'b0, coef_sel(coef.tref, mid_data.channel), 8'd0});

      // the three products of dT
      s2_val_in = s1_val_ff;
      s2_ch_in  = s1_ch_ff;
      s2_d1_in  = s1_d1_ff;
      s2_mt_in  = s1_dt_ff * $signed({1'b0, coef_sel(coef.tempsens, s1_ch_ff)});
      s2_mo_in  = s1_dt_ff * $signed({1'b0, coef_sel(coef.off_tc, s1_ch_ff)});
      s2_ms_in  = s1_dt_ff * $signed({1'b0, coef_sel(coef.sens_tc, s1_ch_ff)});

      // truncating shifts: bias negative values before the arithmetic shift
      mt_adj = s2_mt_ff + (s2_mt_ff[41] ? 42'sd8388607 : 42'sd0);
      mo_adj = s2_mo_ff + (s2_mo_ff[41] ? 42'sd63 : 42'sd0);
      ms_adj = s2_ms_ff + (s2_ms_ff[41] ? 42'sd127 : 42'sd0);
      s3_val_in  = s2_val_ff;
      s3_d1_in   = s2_d1_ff;
      s3_dev_in  = $signed(mt_adj[40:23]);
      s3_off_in  = $signed({5'd0, coef_sel(coef.off_base, s2_ch_ff), 17'd0})
                 + 38'($signed(mo_adj[40:6]));
      s3_sens_in = $signed({6'd0, coef_sel(coef.sens_base, s2_ch_ff), 16'd0})
                 + 38'($signed(ms_adj[40:7]));

      // squared deviation from 20.00 C
      sq_full    = s3_dev_ff * s3_dev_ff;
      s4_val_in  = s3_val_ff;
      s4_d1_in   = s3_d1_ff;
      s4_sq_in   = sq_full[34:0];
      s4_neg_in  = s3_dev_ff[17];
      s4_off_in  = s3_off_ff;
      s4_sens_in = s3_sens_ff;

      // second order: cold branch uses 31/8 and 63/32, warm only 1/16 on offset
      sq31 = {s4_sq_ff, 5'd0} - 40'(s4_sq_ff);
      sq63 = {s4_sq_ff, 6'd0} - 41'(s4_sq_ff);
      off_corr  = s4_neg_ff ? sq31[39:3] : 37'(s4_sq_ff[34:4]);
      sens_corr = s4_neg_ff ? sq63[40:5] : 36'd0;
      s5_val_in  = s4_val_ff;
      s5_d1_in   = s4_d1_ff;
      s5_off_in  = s4_off_ff - $signed({1'b0, off_corr});
      s5_sens_in = s4_sens_ff - $signed({2'b0, sens_corr});

      // D1 * SENS split in two partial products
      s6_val_in = s5_val_ff;
      s6_plo_in = s5_d1_ff * s5_sens_ff[18:0];
      s6_phi_in = $signed({1'b0, s5_d1_ff}) * $signed(s5_sens_ff[37:19]);
      s6_off_in = s5_off_ff;

      s7_val_in = s6_val_ff;
      s7_num_in = (64'(s6_phi_ff) <<< 19) + $signed({21'd0, s6_plo_ff})
                - (64'(s6_off_ff) <<< 21);

      // floor by 2^36 is the upper bits; saturate when they do not fit
      if (s7_num_ff[63:59] == 5'b00000 || s7_num_ff[63:59] == 5'b11111) begin
         p_sat = $signed(s7_num_ff[59:36]);
      end else if (s7_num_ff[63]) begin
         p_sat = 24'sh800000;
      end else begin
         p_sat = 24'sh7FFFFF;
      end
      out_wdata.valid_res           = s7_val_ff;
      out_wdata.pressure_centi_mbar = s7_val_ff ? p_sat : 24'sd0;
   end

   always_ff @(posedge clock) begin
      s1_val_ff  <= s1_val_in;
      s1_ch_ff   <= s1_ch_in;
      s1_d1_ff   <= s1_d1_in;
      s1_dt_ff   <= s1_dt_in;
      s2_val_ff  <= s2_val_in;
      s2_ch_ff   <= s2_ch_in;
      s2_d1_ff   <= s2_d1_in;
      s2_mt_ff   <= s2_mt_in;
      s2_mo_ff   <= s2_mo_in;
      s2_ms_ff   <= s2_ms_in;
      s3_val_ff  <= s3_val_in;
      s3_d1_ff   <= s3_d1_in;
      s3_dev_ff  <= s3_dev_in;
      s3_off_ff  <= s3_off_in;
      s3_sens_ff <= s3_sens_in;
      s4_val_ff  <= s4_val_in;
      s4_d1_ff   <= s4_d1_in;
      s4_sq_ff   <= s4_sq_in;
      s4_neg_ff  <= s4_neg_in;
      s4_off_ff  <= s4_off_in;
      s4_sens_ff <= s4_sens_in;
      s5_val_ff  <= s5_val_in;
      s5_d1_ff   <= s5_d1_in;
      s5_off_ff  <= s5_off_in;
      s5_sens_ff <= s5_sens_in;
      s6_val_ff  <= s6_val_in;
      s6_plo_ff  <= s6_plo_in;
      s6_phi_ff  <= s6_phi_in;
      s6_off_ff  <= s6_off_in;
      s7_val_ff  <= s7_val_in;
      s7_num_ff  <= s7_num_in;
   end

   psc_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_fifo (
      .clock (clock),
      .reset (reset),
      .push  (vld_ff[STAGES]),
      .wdata (out_wdata),
      .pop   (rsp_pop),
      .rdata (out_rdata),
      .full  (out_full),
      .empty (rsp_empty)
   );

   assign rsp_data = rsp_type'(out_rdata);

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= CW'(OUT_DEPTH))
      else $error("outstanding count above output queue depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      vld_ff[STAGES] |-> !out_full)
      else $error("result reached a full output queue");

   a_pipe_credit: assert property (@(posedge clock) disable iff (reset)
      CW'($countones(vld_ff)) <= pend_ff)
      else $error("more requests in flight than credits taken");

endmodule

// ===== design/pressure_sensor_compensation.sv =====
// Second-order pressure compensation for up to four bridge sensors. Each request
// carries a channel number and that channel's raw 24-bit temperature (D2) and
// pressure (D1) conversions; the result is the compensated pressure in 0.01 mbar,
// floor rounded and saturated to 24 bits signed, with valid_res low (and pressure
// zero) when the channel does not exist or its prom-valid bit is clear. The six
// 16-bit coefficients per channel and the prom-valid mask are written through the
// csr port, which is always ready; write them only while no request is in flight.
// A request is taken every cycle while req_full is low; a result passes the input
// queue, seven pipeline registers and the write into the output queue before it
// shows up on the rsp side, where it can then be popped. The rate of one request
// per cycle comes from the fully pipelined arithmetic path; when rsp_pop is held
// low, up to 16 results collect in the output queue and then up to 4 more requests
// wait in the input queue before req_full rises.
module pressure_sensor_compensation #(
   parameter int CHANNELS  = psc_pkg::CHANNELS_DEFAULT,
   parameter int MID_DEPTH = psc_pkg::MID_DEPTH_DEFAULT,
   parameter int OUT_DEPTH = psc_pkg::OUT_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   // request side
   input  logic                      req_push,
   output logic                      req_full,
   input  psc_pkg::req_type          req_data,
   // result side
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output psc_pkg::rsp_type          rsp_data,
   // configuration writes
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [2:0]                csr_index,
   input  logic [psc_pkg::CSR_W-1:0] csr_wdata
);

   import psc_pkg::*;

   logic                     mid_push, mid_pop, mid_full, mid_empty;
   mid_type                  mid_wdata;
   logic [$bits(mid_type)-1:0] mid_rdata;
   coef_type                 coef;

   // coefficient registers never stall a write
   assign csr_ready = 1'b1;

   // input queue is the only thing that can push back on requests
   assign req_full = mid_full;

   // front: coefficient registers, channel check, request into the queue
   psc_front #(
      .CHANNELS (CHANNELS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_push  (req_push),
      .req_data  (req_data),
      .mid_full  (mid_full),
      .mid_push  (mid_push),
      .mid_data  (mid_wdata),
      .coef      (coef)
   );

   // short queue decouples acceptance from the arithmetic pipe
   psc_fifo #(
      .WIDTH ($bits(mid_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_fifo (
      .clock (clock),
      .reset (reset),
      .push  (mid_push),
      .wdata (mid_wdata),
      .pop   (mid_pop),
      .rdata (mid_rdata),
      .full  (mid_full),
      .empty (mid_empty)
   );

   // back: seven-stage compensation pipe with a credit-guarded output queue
   psc_back #(
      .OUT_DEPTH (OUT_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .coef      (coef),
      .mid_empty (mid_empty),
      .mid_data  (mid_type'(mid_rdata)),
      .mid_pop   (mid_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== test/tb_pressure_sensor_compensation.sv =====
`timescale 1ns / 100ps

module tb_pressure_sensor_compensation;
   import psc_pkg::*;

   // the instance keeps its default channel count
   localparam int NUM_CHANNELS = CHANNELS_DEFAULT;
   // register index past the end of the list, writes to it are dropped
   localparam logic [2:0] CSR_UNUSED_INDEX = 3'd7;
   // run is cut off here and reported with errors
   localparam int unsigned CYCLE_LIMIT = 200000;
   // length of the long result hold-off
   localparam int unsigned HOLD_CYCLES = 150;
   // cycles to let pass after the last result
   localparam int unsigned TAIL_CYCLES = 30;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_push = 1'b0;
   logic             req_full;
   req_type          req_data = '0;
   logic             rsp_empty;
   logic             rsp_pop = 1'b0;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [2:0]       csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;

   // coefficient banks and mask as the block should hold them
   logic [CSR_W-1:0]  cfg_sens_base = '0;
   logic [CSR_W-1:0]  cfg_off_base = '0;
   logic [CSR_W-1:0]  cfg_sens_tc = '0;
   logic [CSR_W-1:0]  cfg_off_tc = '0;
   logic [CSR_W-1:0]  cfg_tref = '0;
   logic [CSR_W-1:0]  cfg_tempsens = '0;
   logic [MASK_W-1:0] cfg_mask = '0;

   req_type     conversions_todo[$];   // requests not yet taken by the block
   rsp_type     pressure_due[$];       // compensated pressures still to come out
   rsp_type     want;
   int unsigned req_idle_pct = 30;
   int unsigned rsp_idle_pct = 30;
   int unsigned holds_asked = 0;
   int unsigned holds_done = 0;
   int unsigned hold_left = 0;
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;

   pressure_sensor_compensation dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // second-order compensation in plain 64-bit signed integers; every
   // intermediate stays below 2^62, and / truncates toward zero as required
   function automatic rsp_type compensate_pressure(input req_type conv);
      rsp_type res;
      int      ch;
      longint  c1, c2, c3, c4, c5, c6;
      longint  d1, d2, dt, temp, dev, sq, off, sens, num, p;
      res = '0;
      ch = conv.channel;
      // missing or unchecked channel: invalid, pressure zero
      if (ch >= NUM_CHANNELS || !cfg_mask[ch])
         return res;
      c1 = longint'(cfg_sens_base[16*ch +: 16]);
      c2 = longint'(cfg_off_base[16*ch +: 16]);
      c3 = longint'(cfg_sens_tc[16*ch +: 16]);
      c4 = longint'(cfg_off_tc[16*ch +: 16]);
      c5 = longint'(cfg_tref[16*ch +: 16]);
      c6 = longint'(cfg_tempsens[16*ch +: 16]);
      d2 = longint'(conv.raw_temperature);
      d1 = longint'(conv.raw_pressure);
      dt = d2 - c5 * 256;
      temp = 2000 + (dt * c6) / 64'sd8388608;
      off = c2 * 131072 + (c4 * dt) / 64;
      sens = c1 * 65536 + (c3 * dt) / 128;
      dev = temp - 2000;
      sq = dev * dev;
      // cold branch corrects both terms, warm branch only the offset
      if (temp < 2000) begin
         off = off - (31 * sq) / 8;
         sens = sens - (63 * sq) / 32;
      end else begin
         off = off - sq / 16;
      end
      // arithmetic shift gives the floor division by 2^36
      num = d1 * sens - off * 2097152;
      p = num >>> 36;
      if (p > 64'sd8388607)
         p = 64'sd8388607;
      if (p < -64'sd8388608)
         p = -64'sd8388608;
      res.pressure_centi_mbar = p[RAW_W-1:0];
      res.valid_res = 1'b1;
      return res;
   endfunction

   // raw temperature at which dT is zero for a channel
   function automatic logic [RAW_W-1:0] zero_dt_raw(input logic [1:0] ch);
      return {cfg_tref[16*ch +: 16], 8'd0};
   endfunction

   // timeout watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_pressure_sensor_compensation: errors");
         $finish;
      end
   end

   // request tracker: the block takes a request when push is high and full low
   always @(posedge clock) begin
      if (!reset && req_push && !req_full) begin
         pressure_due.push_back(compensate_pressure(req_data));
         void'(conversions_todo.pop_front());
      end
   end

   // next request goes out on the falling edge, with random gaps
   always @(negedge clock) begin
      if (reset || conversions_todo.size() == 0) begin
         req_push <= 1'b0;
      end else if ($urandom_range(0, 99) >= req_idle_pct) begin
         req_push <= 1'b1;
         req_data <= conversions_todo[0];
      end else begin
         req_push <= 1'b0;
      end
   end

   // result monitor: compare each popped result with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pressure_due.size() == 0) begin
            mismatches = mismatches + 1;
            $error("result popped with no request outstanding");
         end else begin
            want = pressure_due.pop_front();
            if (rsp_data.pressure_centi_mbar !== want.pressure_centi_mbar) begin
               mismatches = mismatches + 1;
               $error("pressure_centi_mbar: expected %0d, got %0d",
                      $signed(want.pressure_centi_mbar),
                      $signed(rsp_data.pressure_centi_mbar));
            end
            if (rsp_data.valid_res !== want.valid_res) begin
               mismatches = mismatches + 1;
               $error("valid_res: expected %0d, got %0d",
                      want.valid_res, rsp_data.valid_res);
            end
         end
      end
   end

   // pop side: random stalls, plus a long hold-off on request from the stimulus
   always @(negedge clock) begin
      if (holds_asked != holds_done) begin
         holds_done = holds_asked;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= !reset && ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   // one register write, shadow copy updated at the handshake; valid stays up
   // so back-to-back writes do not drop it in between
   task automatic write_reg(input logic [2:0] idx, input logic [CSR_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_SENS_BASE:  cfg_sens_base = val;
         CSR_OFF_BASE:   cfg_off_base = val;
         CSR_SENS_TC:    cfg_sens_tc = val;
         CSR_OFF_TC:     cfg_off_tc = val;
         CSR_TREF:       cfg_tref = val;
         CSR_TEMPSENS:   cfg_tempsens = val;
         CSR_VALID_MASK: cfg_mask = val[MASK_W-1:0];
         default: ;
      endcase
   endtask

   // full setting: all six banks, the mask (written wide on purpose) and a
   // stray write to the unused index that must change nothing
   task automatic write_setting(input logic [CSR_W-1:0] sens_base, off_base,
                                sens_tc, off_tc, tref, tempsens, mask_word);
      write_reg(CSR_SENS_BASE, sens_base);
      write_reg(CSR_OFF_BASE, off_base);
      write_reg(CSR_SENS_TC, sens_tc);
      write_reg(CSR_OFF_TC, off_tc);
      write_reg(CSR_TREF, tref);
      write_reg(CSR_TEMPSENS, tempsens);
      write_reg(CSR_VALID_MASK, mask_word);
      write_reg(CSR_UNUSED_INDEX, {$urandom, $urandom});
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic queue_conversion(input logic [1:0] ch,
                                   input logic [RAW_W-1:0] d2, d1);
      req_type conv;
      conv.channel = ch;
      conv.raw_temperature = d2;
      conv.raw_pressure = d1;
      conversions_todo.push_back(conv);
   endtask

   // random conversions: some at the rails, some near the reference
   // temperature so both sides of 20.00 C and the truncation edges are hit
   task automatic queue_random(input int count);
      logic [1:0]       ch;
      logic [RAW_W-1:0] d2, d1;
      int unsigned      pick;
      repeat (count) begin
         ch = 2'($urandom_range(0, 3));
         pick = $urandom_range(0, 99);
         if (pick < 10)
            d2 = $urandom_range(0, 1) ? '1 : '0;
         else if (pick < 45)
            d2 = zero_dt_raw(ch) + RAW_W'($urandom_range(0, 8000)) - RAW_W'(4000);
         else
            d2 = RAW_W'($urandom);
         pick = $urandom_range(0, 99);
         if (pick < 12)
            d1 = $urandom_range(0, 1) ? '1 : '0;
         else
            d1 = RAW_W'($urandom);
         queue_conversion(ch, d2, d1);
      end
   endtask

   // hold the sender back until the block has returned everything
   task automatic wait_drained;
      while (conversions_todo.size() != 0 || pressure_due.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset state: empty mask, so every channel reports invalid
      for (int i = 0; i < 4; i++)
         queue_conversion(i[1:0], RAW_W'($urandom), RAW_W'($urandom));
      queue_conversion(2'd3, '1, '1);
      wait_drained;

      // typical factory coefficients, channel 2 left unchecked; mask written
      // with junk in its upper bits
      write_setting(64'h9C40_8E2A_A1B3_B524, 64'h7D00_9A11_C350_ABCD,
                    64'h5A5A_6100_7F00_7183, 64'h4E20_3A98_6000_6CC2,
                    64'h8000_6400_7000_7B41, 64'h6000_7530_5DC0_6E05,
                    64'hFFFF_FFFF_FFFF_FFFB);
      for (int i = 0; i < 4; i++)
         queue_conversion(i[1:0], zero_dt_raw(i[1:0]), 24'h80_0000);
      queue_conversion(2'd0, '0, '0);
      queue_conversion(2'd0, '1, '1);
      queue_conversion(2'd1, '0, '1);
      queue_conversion(2'd3, '1, '0);
      // around the 20.00 C boundary: dT of -298 is the first step below it,
      // -297 still truncates to exactly 20.00 C
      queue_conversion(2'd0, zero_dt_raw(2'd0) - 24'd298, 24'h8A_3C00);
      queue_conversion(2'd0, zero_dt_raw(2'd0) - 24'd297, 24'h8A_3C00);
      queue_conversion(2'd0, zero_dt_raw(2'd0) - 24'd1, 24'h8A_3C00);
      queue_conversion(2'd0, zero_dt_raw(2'd0) + 24'd1, 24'h8A_3C00);
      queue_conversion(2'd0, zero_dt_raw(2'd0) + 24'd298, 24'h8A_3C00);
      queue_random(300);
      wait_drained;

      // every coefficient at its maximum, all channels checked; long run
      // with no idling on either side
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      write_setting('1, '1, '1, '1, '1, '1, '1);
      queue_conversion(2'd0, '0, '0);
      queue_conversion(2'd1, '0, '1);
      queue_conversion(2'd2, '1, '0);
      queue_conversion(2'd3, '1, '1);
      queue_random(200);
      wait_drained;

      // coldest, most negative sensitivity: full-scale D1 drives the pressure
      // below the bottom of the field and must saturate
      req_idle_pct = 30;
      rsp_idle_pct = 30;
      write_setting('0, '1, '1, '0, '1, '1, 64'hF);
      for (int i = 0; i < 4; i++)
         queue_conversion(i[1:0], '0, '1);
      queue_conversion(2'd1, '0, 24'hC0_0000);
      queue_random(100);
      wait_drained;

      // all coefficients zero, two channels checked
      write_setting('0, '0, '0, '0, '0, '0, 64'h5);
      queue_random(100);
      wait_drained;

      // random settings; the last one with a long hold-off on the pop side
      // while requests keep coming, so the block fills and raises full
      write_setting({$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom});
      queue_random(300);
      wait_drained;

      write_setting({$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom}, 64'hF);
      req_idle_pct = 0;
      holds_asked = holds_asked + 1;
      queue_random(60);
      wait_drained;
      req_idle_pct = 30;
      queue_random(340);
      wait_drained;

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("tb_pressure_sensor_compensation: clean");
      else
         $display("tb_pressure_sensor_compensation: errors");
      $finish;
   end

endmodule

// ===== sim.f =====
design/psc_pkg.sv
design/psc_fifo.sv
design/psc_front.sv
design/psc_back.sv
design/pressure_sensor_compensation.sv
test/tb_pressure_sensor_compensation.sv
